@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the approximate float math unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AFM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("afm assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AFM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("afm assertion failed");

`endif

@@ rtl/afm_pkg.sv @@
// Types, constants and float helper functions of the approximate float math unit.
package afm_pkg;

	localparam int NSTAGES = 5;

	localparam logic [2:0] CMD_NEG   = 3'd0;
	localparam logic [2:0] CMD_LOG2  = 3'd1;
	localparam logic [2:0] CMD_EXP2  = 3'd2;
	localparam logic [2:0] CMD_POW   = 3'd3;
	localparam logic [2:0] CMD_SQRT  = 3'd4;
	localparam logic [2:0] CMD_ISQRT = 3'd5;

	localparam logic [31:0] ONE_BITS      = 32'h3F80_0000;
	localparam logic [31:0] SIGN_BIT      = 32'h8000_0000;
	localparam logic [31:0] MAGIC_ISQ     = 32'h5F37_5A86;
	localparam logic [31:0] HALF_BITS     = 32'h3F00_0000;
	localparam logic [31:0] ONE_HALF_BITS = 32'h3FC0_0000;
	localparam logic [31:0] QNAN_BIT      = 32'h0040_0000;
	localparam logic [31:0] DEFAULT_NAN   = 32'hFFC0_0000;
	localparam logic [31:0] INT_MAX_BITS  = 32'h7FFF_FFFF;
	// 23 in the exponent field: scales a float by 2^-23
	localparam logic [31:0] LOG2_ADJ      = 32'h0B80_0000;
	localparam logic [7:0]  EXP2_SCALE    = 8'd23;

	typedef struct packed {
		logic [NSTAGES-1:0] en;
		logic [NSTAGES-1:0] vld;
	} afm_ctl_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] res;
		logic        sat;
		logic [31:0] y;
		logic [31:0] p;
		logic [31:0] u;
		logic [31:0] v;
	} afm_stage_t;

	// Single-precision multiply, round to nearest even, with subnormals.
	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic               sgn;
		logic [7:0]         ea, eb, ea_eff, eb_eff;
		logic [22:0]        ma, mb;
		logic [23:0]        siga, sigb;
		logic [47:0]        prod, pn, tmp;
		logic [5:0]         lz;
		logic signed [10:0] ex, sh_s;
		logic [10:0]        sh;
		logic               lost, g, st, rnd, ovf;
		logic [30:0]        mag;
		logic [31:0]        r;
		sgn = a[31] ^ b[31];
		ea = a[30:23];
		eb = b[30:23];
		ma = a[22:0];
		mb = b[22:0];
		ea_eff = (ea == 8'd0) ? 8'd1 : ea;
		eb_eff = (eb == 8'd0) ? 8'd1 : eb;
		siga = {ea != 8'd0, ma};
		sigb = {eb != 8'd0, mb};
		prod = siga * sigb;
		lz = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (prod[i])
				lz = 6'(47 - i);
		end
		pn = prod << lz;
		ex = $signed({3'b000, ea_eff}) + $signed({3'b000, eb_eff}) - 11'sd126
			- $signed({5'b00000, lz});
		ovf = 1'b0;
		tmp = '0;
		lost = 1'b0;
		sh = '0;
		if (ex >= 11'sd1) begin
			g = pn[23];
			st = |pn[22:0];
			mag = {ex[7:0], pn[46:24]};
			ovf = (ex >= 11'sd255);
		end else begin
			sh_s = 11'sd1 - ex;
			sh = sh_s;
			if (sh >= 11'd48) begin
				tmp = '0;
				lost = |pn;
			end else begin
				tmp = pn >> sh;
				lost = |(pn & ~({48{1'b1}} << sh));
			end
			g = tmp[23];
			st = (|tmp[22:0]) | lost;
			mag = {8'd0, tmp[46:24]};
		end
		rnd = g & (st | mag[0]);
		mag = mag + 31'(rnd);
		if (ovf || mag[30:23] == 8'hFF)
			r = {sgn, 8'hFF, 23'd0};
		else
			r = {sgn, mag};
		if (ea == 8'hFF && ma != 23'd0)
			r = a | QNAN_BIT;
		else if (eb == 8'hFF && mb != 23'd0)
			r = b | QNAN_BIT;
		else if ((ea == 8'hFF && eb == 8'd0 && mb == 23'd0)
			|| (eb == 8'hFF && ea == 8'd0 && ma == 23'd0))
			r = DEFAULT_NAN;
		else if (ea == 8'hFF || eb == 8'hFF)
			r = {sgn, 8'hFF, 23'd0};
		else if ((ea == 8'd0 && ma == 23'd0) || (eb == 8'd0 && mb == 23'd0))
			r = {sgn, 31'd0};
		return r;
	endfunction

	// Signed 32-bit integer to single precision, round to nearest even.
	function automatic logic [31:0] i2f(input logic [31:0] s);
		logic        sg, g, st, rnd;
		logic [31:0] mag, n;
		logic [4:0]  hb;
		logic [30:0] m;
		sg = s[31];
		mag = sg ? (~s + 32'd1) : s;
		hb = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mag[i])
				hb = 5'(i);
		end
		n = mag << (5'd31 - hb);
		g = n[7];
		st = |n[6:0];
		rnd = g & (st | n[8]);
		m = {8'd127 + {3'b000, hb}, n[30:8]} + 31'(rnd);
		return (mag == 32'd0) ? 32'd0 : {sg, m};
	endfunction

	// Float scaled by 2^k, truncated to int32 with saturation; bit 32 flags a clamp.
	function automatic logic [32:0] f2i(input logic [31:0] f, input logic [7:0] k);
		logic [7:0]  e;
		logic [22:0] m;
		logic [9:0]  ue, ex;
		logic [31:0] sig, mag;
		logic [32:0] r;
		e = f[30:23];
		m = f[22:0];
		ue = {2'b00, e} + {2'b00, k};
		ex = ue - 10'd127;
		sig = {8'd0, 1'b1, m};
		mag = (ex >= 10'd23) ? (sig << (ex - 10'd23)) : (sig >> (10'd23 - ex));
		if (e == 8'hFF && m != 23'd0)
			r = {1'b1, 32'd0};
		else if (e == 8'd0 || ue < 10'd127)
			r = '0;
		else if (ex >= 10'd31) begin
			if (f[31] && ex == 10'd31 && m == 23'd0)
				r = {1'b0, SIGN_BIT};
			else
				r = {1'b1, f[31] ? SIGN_BIT : INT_MAX_BITS};
		end else
			r = {1'b0, f[31] ? (~mag + 32'd1) : mag};
		return r;
	endfunction

	// a - b for a finite a, round to nearest even, with subnormals.
	function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] nb, big, sml, r;
		logic [7:0]  ebg, esm, eb_eff, es_eff, d, ls;
		logic [8:0]  ex;
		logic [26:0] sig_b, sig_s, s_sh, n;
		logic [27:0] sum;
		logic [4:0]  hb;
		logic        sticky, g, st, rnd;
		logic [30:0] mag;
		nb = b ^ SIGN_BIT;
		if (a[30:0] >= nb[30:0]) begin
			big = a;
			sml = nb;
		end else begin
			big = nb;
			sml = a;
		end
		ebg = big[30:23];
		esm = sml[30:23];
		eb_eff = (ebg == 8'd0) ? 8'd1 : ebg;
		es_eff = (esm == 8'd0) ? 8'd1 : esm;
		sig_b = {ebg != 8'd0, big[22:0], 3'b000};
		sig_s = {esm != 8'd0, sml[22:0], 3'b000};
		d = eb_eff - es_eff;
		if (d >= 8'd27) begin
			s_sh = '0;
			sticky = |sig_s;
		end else begin
			s_sh = sig_s >> d;
			sticky = |(sig_s & ~({27{1'b1}} << d));
		end
		s_sh[0] = s_sh[0] | sticky;
		if (big[31] == sml[31])
			sum = {1'b0, sig_b} + {1'b0, s_sh};
		else
			sum = {1'b0, sig_b} - {1'b0, s_sh};
		hb = 5'd0;
		for (int i = 0; i < 28; i++) begin
			if (sum[i])
				hb = 5'(i);
		end
		ls = 8'd0;
		if (hb == 5'd27) begin
			n = {sum[27:2], sum[1] | sum[0]};
			ex = {1'b0, eb_eff} + 9'd1;
		end else begin
			ls = 8'(5'd26 - hb);
			if (ls > eb_eff - 8'd1)
				ls = eb_eff - 8'd1;
			n = sum[26:0] << ls;
			ex = {1'b0, eb_eff} - {1'b0, ls};
		end
		g = n[2];
		st = |n[1:0];
		rnd = g & (st | n[3]);
		mag = {n[26] ? ex[7:0] : 8'd0, n[25:3]} + 31'(rnd);
		if (ex >= 9'd255)
			r = {big[31], 8'hFF, 23'd0};
		else
			r = {big[31], mag};
		if (sum == 28'd0)
			r = 32'd0;
		if (b[30:23] == 8'hFF && b[22:0] != 23'd0)
			r = b | QNAN_BIT;
		else if (b[30:23] == 8'hFF)
			r = nb;
		return r;
	endfunction

endpackage

@@ rtl/afm_pipe_ctrl.sv @@
// Valid bits and stage enables of the five-stage pipeline.
module afm_pipe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  logic              result_ready,
	output afm_pkg::afm_ctl_t ctl
);
	import afm_pkg::*;

	logic [NSTAGES-1:0] vld_q;
	logic [NSTAGES-1:0] en;

	// a stage may load when it is empty or its content moves on
	always_comb begin
		en[NSTAGES-1] = !vld_q[NSTAGES-1] || result_ready;
		for (int k = NSTAGES - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= valid;
			for (int k = 1; k < NSTAGES; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;
endmodule

@@ rtl/afm_datapath.sv @@
// Five-stage float datapath: seed and scaling, products, subtract and convert, final product.
module afm_datapath (
	input  logic              clk,
	input  afm_pkg::afm_ctl_t ctl,
	input  logic [2:0]        cmd,
	input  logic [31:0]       x_bits,
	input  logic [31:0]       p_bits,
	output logic [31:0]       result_bits,
	output logic              saturated
);
	import afm_pkg::*;

	afm_stage_t data_s1, data_s2, data_s3, data_s4, data_s5;
	afm_stage_t nxt1, nxt2, nxt3, nxt4, nxt5;
	logic [32:0] exp_conv, pow_conv;

	assign exp_conv = f2i(x_bits, EXP2_SCALE);
	assign pow_conv = f2i(data_s3.v, 8'd0);

	// stage 1: half of x, bit difference, seed, single-step operations
	always_comb begin
		nxt1.cmd = cmd;
		nxt1.p   = p_bits;
		nxt1.u   = fmul(x_bits, HALF_BITS);
		nxt1.v   = x_bits - ONE_BITS;
		nxt1.y   = MAGIC_ISQ - {x_bits[31], x_bits[31:1]};
		nxt1.res = '0;
		nxt1.sat = 1'b0;
		unique case (cmd)
			CMD_NEG:  nxt1.res = x_bits ^ SIGN_BIT;
			CMD_EXP2: begin
				nxt1.res = exp_conv[31:0] + ONE_BITS;
				nxt1.sat = exp_conv[32];
			end
			CMD_SQRT: nxt1.res = {1'b0, x_bits[31:1]} + {1'b0, ONE_BITS[31:1]};
			default: ;
		endcase
	end

	// stage 2: a = xhalf * y, d = float(diff)
	always_comb begin
		nxt2   = data_s1;
		nxt2.u = fmul(data_s1.u, data_s1.y);
		nxt2.v = i2f(data_s1.v);
	end

	// stage 3: b = a * y, t = p * d, log2 from d
	always_comb begin
		nxt3   = data_s2;
		nxt3.u = fmul(data_s2.u, data_s2.y);
		nxt3.v = fmul(data_s2.p, data_s2.v);
		if (data_s2.cmd == CMD_LOG2)
			nxt3.res = (data_s2.v == 32'd0) ? 32'd0 : data_s2.v - LOG2_ADJ;
	end

	// stage 4: c = 1.5 - b, pow conversion
	always_comb begin
		nxt4   = data_s3;
		nxt4.u = fsub(ONE_HALF_BITS, data_s3.u);
		if (data_s3.cmd == CMD_POW) begin
			nxt4.res = pow_conv[31:0] + ONE_BITS;
			nxt4.sat = pow_conv[32];
		end
	end

	// stage 5: r = y * c
	always_comb begin
		nxt5 = data_s4;
		if (data_s4.cmd == CMD_ISQRT)
			nxt5.res = fmul(data_s4.y, data_s4.u);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0])
			data_s1 <= nxt1;
		if (ctl.en[1])
			data_s2 <= nxt2;
		if (ctl.en[2])
			data_s3 <= nxt3;
		if (ctl.en[3])
			data_s4 <= nxt4;
		if (ctl.en[4])
			data_s5 <= nxt5;
	end

	assign result_bits = data_s5.res;
	assign saturated   = data_s5.sat;
endmodule

@@ rtl/approx_float_math_unit.sv @@
// Top level of the approximate single-precision math unit.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------
//  in      | valid / ready         | cmd, x_bits, p_bits
//  out     | result_valid / ready  | result_bits, saturated
//
// An accepted item moves one pipeline stage per cycle unless a stall holds
// it, through data_s1 to data_s5, raises result_valid when it reaches
// data_s5 and leaves when result_ready is high.
// One item enters per cycle while the output side keeps taking results.
// Reset clears the valid bits only. A stall holds each full stage whose
// successor is held as well; empty stages still fill, so bubbles close up.
module approx_float_math_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [2:0]  cmd,
	input  logic [31:0] x_bits,
	input  logic [31:0] p_bits,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] result_bits,
	output logic        saturated
);
	import afm_pkg::*;

	afm_ctl_t ctl;

	afm_pipe_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (valid),
		.result_ready (result_ready),
		.ctl          (ctl)
	);

	afm_datapath u_dp (
		.clk         (clk),
		.ctl         (ctl),
		.cmd         (cmd),
		.x_bits      (x_bits),
		.p_bits      (p_bits),
		.result_bits (result_bits),
		.saturated   (saturated)
	);

	assign ready        = ctl.en[0];
	assign result_valid = ctl.vld[NSTAGES-1];

`include "assert_macros.svh"

	`AFM_ASSERT_IMPL(a_empty_is_ready, ctl.vld == '0, ready)
	`AFM_ASSERT_NEXT(a_accept_fills_s1, valid && ready, ctl.vld[0])
	`AFM_ASSERT_IMPL(a_full_stall_blocks, (&ctl.vld) && !result_ready, !ready)
endmodule
